// ----- src/pcl_pkg.sv -----
`timescale 1ns / 1ps
package pcl_pkg;

    localparam int CMD_W    = 2;
    localparam int POS_W    = 6;
    localparam int LETTER_W = 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd2;

    // Port strobes of the entry store.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // Result of one command, minus the entry count.
    typedef struct packed {
        logic                ok;
        logic [LETTER_W-1:0] data;
    } t_result;

endpackage

// ----- src/pcl_store.sv -----
`timescale 1ns / 1ps
module pcl_store #(
    parameter int DEPTH = 16
) (
    input  logic                           i_clk,
    input  pcl_pkg::t_mem_ctl              i_ctl,
    input  logic [$clog2(DEPTH)-1:0]       i_waddr,
    input  logic [pcl_pkg::LETTER_W-1:0]   i_wdata,
    input  logic [$clog2(DEPTH)-1:0]       i_raddr,
    output logic [pcl_pkg::LETTER_W-1:0]   o_rdata
);
    import pcl_pkg::*;

    logic [LETTER_W-1:0] r_mem [DEPTH];
    logic [LETTER_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/pcl_ctrl.sv -----
`timescale 1ns / 1ps
module pcl_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pcl_pkg::CMD_W-1:0]      i_cmd,
    input  logic [pcl_pkg::POS_W-1:0]      i_pos,
    input  logic [pcl_pkg::LETTER_W-1:0]   i_letter,
    input  logic                           i_res_take,
    output logic                           o_busy,
    output logic                           o_res_valid,
    output pcl_pkg::t_result               o_res,
    output logic [$clog2(DEPTH+1)-1:0]     o_len
);
    import pcl_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_len, n_len;
    logic                r_rd_valid, n_rd_valid;
    logic [AW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_ra, n_ra;
    logic [AW-1:0]       r_wa, n_wa;
    logic [CW-1:0]       r_left, n_left;
    logic                r_up, n_up;
    logic                r_ins, n_ins;
    logic [LETTER_W-1:0] r_letter, n_letter;
    logic                r_ok, n_ok;
    logic [LETTER_W-1:0] r_data, n_data;

    t_mem_ctl            mem_ctl;
    logic [AW-1:0]       mem_waddr;
    logic [LETTER_W-1:0] mem_wdata;
    logic [LETTER_W-1:0] mem_rdata;

    logic signed [SW-1:0] pos_s;
    logic signed [SW-1:0] len_s;
    logic signed [SW-1:0] get_idx_s;
    logic signed [SW-1:0] gap_s;
    logic                 pos_neg;
    logic                 ins_ok;
    logic                 rem_ok;
    logic                 get_ok;
    logic [AW-1:0]        idx_step;
    logic                 shift_end;

    assign pos_s     = {{(SW - POS_W){i_pos[POS_W-1]}}, i_pos};
    assign len_s     = {{(SW - CW){1'b0}}, r_len};
    assign pos_neg   = pos_s[SW-1];
    assign get_idx_s = pos_neg ? (len_s + pos_s) : pos_s;
    assign gap_s     = len_s - pos_s;

    assign ins_ok = !pos_neg && (pos_s <= len_s) && (r_len != CW'(DEPTH));
    assign rem_ok = !pos_neg && (pos_s < len_s);
    assign get_ok = (r_len != '0) && (pos_s < len_s) && (pos_s >= -len_s);

    // Shared address stepper: walk down for insert, up for remove.
    assign idx_step  = r_idx + (r_up ? AW'(1) : {AW{1'b1}});
    assign shift_end = (r_left == '0) && !r_rd_valid;

    always_comb begin
        mem_ctl.re = ((r_state == ST_SHIFT) && (r_left != '0)) || (r_state == ST_READ);
        mem_ctl.we = (r_state == ST_SHIFT) && (r_rd_valid || (shift_end && r_ins));
    end
    assign mem_waddr = r_wa;
    assign mem_wdata = r_rd_valid ? mem_rdata : r_letter;

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_rd_valid = r_rd_valid;
        n_idx      = r_idx;
        n_ra       = r_ra;
        n_wa       = r_wa;
        n_left     = r_left;
        n_up       = r_up;
        n_ins      = r_ins;
        n_letter   = r_letter;
        n_ok       = r_ok;
        n_data     = r_data;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_ok       = 1'b0;
                    n_data     = '0;
                    n_rd_valid = 1'b0;
                    n_letter   = i_letter;
                    n_state    = ST_DONE;
                    priority if (i_cmd == CMD_INSERT && ins_ok) begin
                        n_ins   = 1'b1;
                        n_up    = 1'b0;
                        n_idx   = AW'(r_len - CW'(1));
                        n_wa    = r_len[AW-1:0];
                        n_left  = gap_s[CW-1:0];
                        n_state = ST_SHIFT;
                    end else if (i_cmd == CMD_REMOVE && rem_ok) begin
                        n_ins   = 1'b0;
                        n_up    = 1'b1;
                        n_idx   = pos_s[AW-1:0] + AW'(1);
                        n_wa    = pos_s[AW-1:0];
                        n_left  = gap_s[CW-1:0] - CW'(1);
                        n_state = ST_SHIFT;
                    end else if (i_cmd == CMD_GET && get_ok) begin
                        n_idx   = get_idx_s[AW-1:0];
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SHIFT: begin
                if (r_rd_valid) begin
                    n_wa = r_ra;
                end
                if (r_left != '0) begin
                    n_ra       = r_idx;
                    n_idx      = idx_step;
                    n_left     = r_left - CW'(1);
                    n_rd_valid = 1'b1;
                end else begin
                    n_rd_valid = 1'b0;
                end
                if (shift_end) begin
                    n_len   = r_ins ? (r_len + CW'(1)) : (r_len - CW'(1));
                    n_ok    = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                n_data  = mem_rdata;
                n_ok    = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_len      <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_rd_valid <= n_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_ra     <= n_ra;
        r_wa     <= n_wa;
        r_left   <= n_left;
        r_up     <= n_up;
        r_ins    <= n_ins;
        r_letter <= n_letter;
        r_ok     <= n_ok;
        r_data   <= n_data;
    end

    pcl_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    assign o_busy      = (r_state != ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res.ok    = r_ok;
    assign o_res.data  = r_data;
    assign o_len       = r_len;

    a_we_in_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.we |-> (r_state == ST_SHIFT))
        else $error("store written outside of a shift pass");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && !r_ok) |-> (r_data == '0))
        else $error("rejected command carries nonzero data");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == ST_IDLE))
        else $error("command started while busy");

    a_len_only_at_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_SHIFT) |=> $stable(r_len))
        else $error("entry count changed outside of a shift pass");

endmodule

// ----- src/positional_char_list.sv -----
`timescale 1ns / 1ps
// A rejected command goes straight to the result; a get first reads the entry store,
// and insert or remove at position p into n entries shifts the entries between p and the tail.
// One command at a time; the entry store moves one entry per cycle during an insert/remove,
// so these take longer the further the position lies from the tail.
// Reset (synchronous, active low) empties the list and drops any pending result;
// entry storage is not cleared.
module positional_char_list #(
    parameter int DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [pcl_pkg::CMD_W-1:0]      i_cmd,
    input  logic [pcl_pkg::POS_W-1:0]      i_position,
    input  logic [pcl_pkg::LETTER_W-1:0]   i_letter,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_ok,
    output logic [pcl_pkg::LETTER_W-1:0]   o_data,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);
    import pcl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic                busy;
    logic                start;
    logic                res_valid;
    logic                res_take;
    t_result             res;
    logic [CW-1:0]       len;

    logic                r_out_valid, n_out_valid;
    logic                r_out_ok;
    logic [LETTER_W-1:0] r_out_data;
    logic [CW-1:0]       r_out_count;

    // Hold off new beats while the sequencer owns a command, including the
    // cycles it waits for the output register to free up.
    assign o_stall = busy;
    assign start   = i_valid && !busy;

    // Load the finished result when the output register is empty or being drained.
    assign res_take = res_valid && (!r_out_valid || !i_stall);

    pcl_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .i_pos       (i_position),
        .i_letter    (i_letter),
        .i_res_take  (res_take),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_len       (len)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_take) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            // drop the beat once the consumer has taken it
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_ok    <= res.ok;
            r_out_data  <= res.data;
            r_out_count <= len;
        end
    end

    assign o_valid = r_out_valid;
    assign o_ok    = r_out_ok;
    assign o_data  = r_out_data;
    assign o_count = r_out_count;

endmodule

// ----- bench/tb_positional_char_list.sv -----
`timescale 1ns / 1ps
module tb_positional_char_list;

    import pcl_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT = 250000;
    // Drain allowance once the last result is in: longest insert plus margin.
    localparam int DRAIN_CYCLES = DEPTH + 10;

    // The one command code the block does not implement.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic             ok;
        logic [LETTER_W-1:0] data;
        logic [CNT_W-1:0] count;
    } t_list_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [CMD_W-1:0]       i_cmd;
    logic [POS_W-1:0]       i_position;
    logic [LETTER_W-1:0]    i_letter;
    logic                   o_valid;
    logic                   i_stall;
    logic                   o_ok;
    logic [LETTER_W-1:0]    o_data;
    logic [CNT_W-1:0]       o_count;

    // Shadow copy of the list, advanced once per accepted command beat.
    logic [LETTER_W-1:0]    shadow_bytes [DEPTH];
    int                     shadow_len;

    // Results predicted but not yet seen on the result channel, oldest first.
    t_list_result           pending_results [$];

    int                     err_count;
    int                     cycle_count;
    int                     result_count;
    int                     idle_pct;
    int                     stall_pct;
    bit                     growing;

    positional_char_list #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .i_position (i_position),
        .i_letter   (i_letter),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_ok       (o_ok),
        .o_data     (o_data),
        .o_count    (o_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop: the slowest legal run is far below this.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_positional_char_list: FAIL");
            $finish;
        end
    end

    // Receiver back-pressure: redraw the stall at every falling edge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Apply one command to the shadow list and return what the block must answer.
    function automatic t_list_result apply_command(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [POS_W-1:0] pos,
                                                   input logic [LETTER_W-1:0] letter);
        t_list_result res;
        int p;
        int n;
        p = int'(pos);
        n = shadow_len;
        res.ok   = 1'b0;
        res.data = '0;
        case (cmd)
            CMD_INSERT: begin
                // Open a slot at p by moving the tail up one place.
                if (p >= 0 && p <= n && n < DEPTH) begin
                    for (int i = n; i > p; i--)
                        shadow_bytes[i] = shadow_bytes[i-1];
                    shadow_bytes[p] = letter;
                    shadow_len++;
                    res.ok = 1'b1;
                end
            end
            CMD_REMOVE: begin
                // Position equal to count is out of range and must not touch the list.
                if (p >= 0 && p < n) begin
                    for (int i = p; i + 1 < n; i++)
                        shadow_bytes[i] = shadow_bytes[i+1];
                    shadow_len--;
                    res.ok = 1'b1;
                end
            end
            CMD_GET: begin
                // Negative positions count back from the tail: -1 is the last entry.
                if (n > 0 && p < n && p >= -n) begin
                    res.data = shadow_bytes[(p >= 0) ? p : n + p];
                    res.ok   = 1'b1;
                end
            end
            default: begin
                // Unused code: rejected, list untouched.
            end
        endcase
        res.count = shadow_len[CNT_W-1:0];
        return res;
    endfunction

    // Send one command beat. Entered and left just after a falling edge;
    // valid stays high on return so back-to-back beats never drop it.
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic signed [POS_W-1:0] pos,
                                input logic [LETTER_W-1:0] letter);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_position <= pos;
        i_letter   <= letter;
        // Hold the beat until the block takes it.
        forever begin
            @(posedge i_clk);
            if (!o_stall)
                break;
        end
        pending_results.push_back(apply_command(cmd, pos, letter));
        @(negedge i_clk);
    endtask

    // Result checker: compare each accepted result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_error($sformatf("result %0d arrived with nothing expected", result_count));
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok)
                    report_error($sformatf("result %0d ok: expected %0b got %0b",
                                           result_count, want.ok, o_ok));
                if (o_data !== want.data)
                    report_error($sformatf("result %0d data: expected %02h got %02h",
                                           result_count, want.data, o_data));
                if (o_count !== want.count)
                    report_error($sformatf("result %0d count: expected %0d got %0d",
                                           result_count, want.count, o_count));
            end
        end
    end

    // Empty list: every read or delete is refused, and so are an insert past the end and the unused code.
    task automatic test_empty_list();
        send_command(CMD_GET,    6'sd0,  8'h11);
        send_command(CMD_REMOVE, 6'sd0,  8'h22);
        send_command(CMD_GET,    -6'sd1, 8'h33);
        send_command(CMD_INSERT, 6'sd1,  8'h44);
        send_command(CMD_UNUSED, 6'sd0,  8'h55);
    endtask

    // Insert at head, at count, at a negative position and past the end.
    task automatic test_insert_bounds();
        send_command(CMD_INSERT, 6'sd0,   8'hFF);
        send_command(CMD_INSERT, 6'sd1,   8'h00);
        send_command(CMD_INSERT, 6'sd0,   8'hA5);
        send_command(CMD_INSERT, -6'sd1,  8'h5A);
        send_command(CMD_INSERT, 6'sd31,  8'h5A);
    endtask

    // Read from the head side and from the tail side, including both range limits.
    task automatic test_get_from_both_ends();
        send_command(CMD_GET, 6'sd0,   8'h00);
        send_command(CMD_GET, 6'sd2,   8'h00);
        send_command(CMD_GET, -6'sd1,  8'h00);
        send_command(CMD_GET, -6'sd3,  8'h00);
        send_command(CMD_GET, -6'sd4,  8'h00);
        send_command(CMD_GET, 6'sd3,   8'h00);
        send_command(CMD_GET, -6'sd32, 8'hFF);
    endtask

    // Remove at count and at a negative position (both must be refused), then middle, tail and head.
    task automatic test_remove_bounds();
        send_command(CMD_REMOVE, 6'sd3,  8'h00);
        send_command(CMD_REMOVE, -6'sd1, 8'h00);
        send_command(CMD_REMOVE, 6'sd1,  8'h00);
        send_command(CMD_REMOVE, 6'sd1,  8'h00);
        send_command(CMD_REMOVE, 6'sd0,  8'h00);
    endtask

    // Random traffic that swings the list between empty and full, so the
    // full-list insert and empty-list paths recur; most positions are legal.
    task automatic test_random_traffic(input int n_items, input int send_idle,
                                       input int recv_stall);
        logic [CMD_W-1:0]       cmd;
        logic signed [POS_W-1:0] pos;
        int                     roll;
        int                     n;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        for (int k = 0; k < n_items; k++) begin
            n = shadow_len;
            if (n == DEPTH && $urandom_range(3) == 0)
                growing = 1'b0;
            if (n == 0 && $urandom_range(3) == 0)
                growing = 1'b1;
            roll = $urandom_range(99);
            if (roll < 5)
                cmd = CMD_UNUSED;
            else if (roll < 25)
                cmd = CMD_GET;
            else if (roll < 85)
                cmd = growing ? CMD_INSERT : CMD_REMOVE;
            else
                cmd = growing ? CMD_REMOVE : CMD_INSERT;
            roll = $urandom_range(99);
            if (roll < 12) begin
                pos = POS_W'($urandom);
            end else if (roll < 18) begin
                // Right at count: legal for insert, one past the end otherwise.
                pos = POS_W'(n);
            end else begin
                case (cmd)
                    CMD_INSERT: pos = POS_W'($urandom_range(n, 0));
                    CMD_REMOVE: pos = (n > 0) ? POS_W'($urandom_range(n - 1, 0)) : '0;
                    CMD_GET:    pos = (n > 0) ?
                                      POS_W'(int'($urandom_range(2 * n - 1, 0)) - n) : '0;
                    default:    pos = POS_W'($urandom);
                endcase
            end
            send_command(cmd, pos, LETTER_W'($urandom_range(255)));
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_cmd      = CMD_INSERT;
        i_position = '0;
        i_letter   = '0;
        i_stall    = 1'b0;
        err_count    = 0;
        cycle_count  = 0;
        result_count = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        growing      = 1'b1;
        shadow_len   = 0;
        foreach (shadow_bytes[i])
            shadow_bytes[i] = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_list();
        test_insert_bounds();
        test_get_from_both_ends();
        test_remove_bounds();
        test_random_traffic(100, 0,  0);
        test_random_traffic(100, 45, 0);
        test_random_traffic(100, 0,  45);
        test_random_traffic(100, 17, 17);

        // Drop valid, wait out every prediction, then watch for stray results.
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("tb_positional_char_list: PASS");
        end else begin
            $display("tb_positional_char_list: FAIL");
        end
        $finish;
    end

endmodule
